// File: rtl/rmcc_pkg.sv
// Shared constants, opcodes and types for the reachability merge cycle check.
`timescale 1ns / 1ps

package rmcc_pkg;

    localparam int MAX_OPS_DEF = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int OPC_W       = 3;

    localparam logic [CNT_W-1:0] OP_COUNT_RST = 7'd64;

    localparam logic [OPC_W-1:0] OPC_CLEAR  = 3'd0;
    localparam logic [OPC_W-1:0] OPC_START  = 3'd1;
    localparam logic [OPC_W-1:0] OPC_SUCC   = 3'd2;
    localparam logic [OPC_W-1:0] OPC_MEMBER = 3'd3;
    localparam logic [OPC_W-1:0] OPC_QUERY  = 3'd4;

    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_START,
        CMD_SUCC,
        CMD_MEMBER,
        CMD_QUERY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUCC,
        ST_MEMBER,
        ST_WALK,
        ST_DRAIN
    } t_back_state;

endpackage

// File: rtl/rmcc_front.sv
// Front end: takes command words, checks index range and decodes them into queue entries.
`timescale 1ns / 1ps

module rmcc_front (
    input  logic                      start,
    output logic                      busy,
    input  logic [rmcc_pkg::OPC_W-1:0] i_opcode,
    input  logic [rmcc_pkg::IDX_W-1:0] i_op_index,
    input  logic [rmcc_pkg::CNT_W-1:0] i_live_n,
    input  logic                      i_full,
    output logic                      o_push,
    output rmcc_pkg::t_cmd            o_cmd
);

    logic idx_ok;
    logic keep;

    assign busy   = i_full;
    assign idx_ok = {1'b0, i_op_index} < i_live_n;

    always_comb begin
        keep         = 1'b0;
        o_cmd.kind   = rmcc_pkg::CMD_CLEAR;
        o_cmd.idx    = i_op_index;
        unique case (i_opcode)
            rmcc_pkg::OPC_CLEAR: begin
                keep       = 1'b1;
                o_cmd.kind = rmcc_pkg::CMD_CLEAR;
            end
            rmcc_pkg::OPC_START: begin
                keep       = idx_ok;
                o_cmd.kind = rmcc_pkg::CMD_START;
            end
            rmcc_pkg::OPC_SUCC: begin
                keep       = idx_ok;
                o_cmd.kind = rmcc_pkg::CMD_SUCC;
            end
            rmcc_pkg::OPC_MEMBER: begin
                keep       = idx_ok;
                o_cmd.kind = rmcc_pkg::CMD_MEMBER;
            end
            rmcc_pkg::OPC_QUERY: begin
                keep       = 1'b1;
                o_cmd.kind = rmcc_pkg::CMD_QUERY;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // drop out-of-range and unused words here; the back end never sees them
    assign o_push = start & ~i_full & keep;

endmodule

// File: rtl/rmcc_queue.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module rmcc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rmcc_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output rmcc_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);

    rmcc_pkg::t_cmd r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_cmd   = r_slot[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            priority if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue underflow");
`endif

endmodule

// File: rtl/rmcc_back.sv
// Back end: reach-row memory, group registers and the query walk.
`timescale 1ns / 1ps

module rmcc_back #(
    parameter int MAX_OPS = rmcc_pkg::MAX_OPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rmcc_pkg::CNT_W-1:0] i_live_n,
    input  logic                      i_empty,
    input  rmcc_pkg::t_cmd            i_cmd,
    output logic                      o_pop,
    output logic                      o_result_valid,
    output logic                      o_creates_cycle
);

    localparam int IW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam logic [MAX_OPS-1:0] ONE  = MAX_OPS'(1);
    localparam logic [IW-1:0]      LAST = IW'(MAX_OPS - 1);

    // row storage: one row per operation, valid bit per row stands in for a cleared row
    logic [MAX_OPS-1:0] r_mem [MAX_OPS];
    logic [MAX_OPS-1:0] r_row_vld;
    logic [MAX_OPS-1:0] r_rd_data;
    logic               r_rd_vld;

    rmcc_pkg::t_back_state r_state;
    rmcc_pkg::t_back_state n_state;

    logic [IW-1:0]      r_cur;
    logic [MAX_OPS-1:0] r_cur_row;
    logic [MAX_OPS-1:0] r_mask;
    logic [MAX_OPS-1:0] r_reach;
    logic [MAX_OPS-1:0] r_ext;
    logic [IW-1:0]      r_walk;
    logic               r_chk;
    logic [IW-1:0]      r_chk_addr;
    logic               r_hit;
    logic               r_out_valid;
    logic               r_out_bit;

    logic [IW-1:0]      cmd_idx;
    logic [MAX_OPS-1:0] self_bit;
    logic               cur_live;
    logic [MAX_OPS-1:0] live_mask;
    logic [MAX_OPS-1:0] rd_row;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [MAX_OPS-1:0] wr_data;
    logic               hit_next;

    assign cmd_idx  = i_cmd.idx[IW-1:0];
    assign self_bit = ONE << cmd_idx;
    assign cur_live = rmcc_pkg::CNT_W'(r_cur) < i_live_n;
    assign rd_row   = r_rd_vld ? r_rd_data : '0;
    assign hit_next = r_hit | (r_chk & r_ext[r_chk_addr] & (|(rd_row & r_mask)));

    always_comb begin
        for (int x = 0; x < MAX_OPS; x++) begin
            live_mask[x] = rmcc_pkg::CNT_W'(x) < i_live_n;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmcc_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.kind)
                        rmcc_pkg::CMD_SUCC:   n_state = cur_live ? rmcc_pkg::ST_SUCC
                                                                 : rmcc_pkg::ST_IDLE;
                        rmcc_pkg::CMD_MEMBER: n_state = rmcc_pkg::ST_MEMBER;
                        rmcc_pkg::CMD_QUERY:  n_state = rmcc_pkg::ST_WALK;
                        default:              n_state = rmcc_pkg::ST_IDLE;
                    endcase
                end
            end
            rmcc_pkg::ST_SUCC:   n_state = rmcc_pkg::ST_IDLE;
            rmcc_pkg::ST_MEMBER: n_state = rmcc_pkg::ST_IDLE;
            rmcc_pkg::ST_WALK:   n_state = (r_walk == LAST) ? rmcc_pkg::ST_DRAIN
                                                            : rmcc_pkg::ST_WALK;
            rmcc_pkg::ST_DRAIN:  n_state = rmcc_pkg::ST_IDLE;
            default:             n_state = rmcc_pkg::ST_IDLE;
        endcase
    end

    // outputs: queue pop, memory port controls
    always_comb begin
        o_pop   = 1'b0;
        rd_addr = cmd_idx;
        wr_en   = 1'b0;
        wr_addr = cmd_idx;
        wr_data = self_bit;
        unique case (r_state)
            rmcc_pkg::ST_IDLE: begin
                o_pop = ~i_empty;
                wr_en = ~i_empty & (i_cmd.kind == rmcc_pkg::CMD_START);
            end
            rmcc_pkg::ST_SUCC: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = r_cur_row | rd_row;
            end
            rmcc_pkg::ST_WALK: begin
                rd_addr = r_walk;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_row_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (o_pop && i_cmd.kind == rmcc_pkg::CMD_CLEAR) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmcc_pkg::ST_IDLE;
            r_cur       <= '0;
            r_cur_row   <= '0;
            r_mask      <= '0;
            r_reach     <= '0;
            r_walk      <= '0;
            r_chk       <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            r_chk       <= (r_state == rmcc_pkg::ST_WALK);
            unique case (r_state)
                rmcc_pkg::ST_IDLE: begin
                    if (!i_empty) begin
                        unique case (i_cmd.kind)
                            rmcc_pkg::CMD_CLEAR: begin
                                r_cur_row <= '0;
                            end
                            rmcc_pkg::CMD_START: begin
                                r_cur     <= cmd_idx;
                                r_cur_row <= self_bit;
                            end
                            rmcc_pkg::CMD_MEMBER: begin
                                r_mask <= r_mask | self_bit;
                            end
                            rmcc_pkg::CMD_QUERY: begin
                                r_walk <= '0;
                                r_hit  <= 1'b0;
                            end
                            default: begin
                                r_hit <= r_hit;
                            end
                        endcase
                    end
                end
                rmcc_pkg::ST_SUCC: begin
                    r_cur_row <= wr_data;
                end
                rmcc_pkg::ST_MEMBER: begin
                    r_reach <= r_reach | rd_row;
                end
                rmcc_pkg::ST_WALK: begin
                    r_walk <= r_walk + IW'(1);
                    r_hit  <= hit_next;
                end
                rmcc_pkg::ST_DRAIN: begin
                    r_out_valid <= 1'b1;
                    r_mask      <= '0;
                    r_reach     <= '0;
                end
                default: begin
                    r_hit <= r_hit;
                end
            endcase
        end
    end

    // walk payload: external reached set, check address, answer bit
    always_ff @(posedge i_clk) begin
        if (r_state == rmcc_pkg::ST_IDLE) begin
            r_ext <= r_reach & ~r_mask & live_mask;
        end
        r_chk_addr <= r_walk;
        if (r_state == rmcc_pkg::ST_DRAIN) begin
            r_out_bit <= hit_next;
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_creates_cycle = r_out_bit;

`ifndef SYNTH
    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == rmcc_pkg::ST_DRAIN))
        else $error("result strobe without a finished walk");

    a_group_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmcc_pkg::ST_DRAIN) |=> (r_mask == '0 && r_reach == '0))
        else $error("group not cleared after query");
`endif

endmodule

// File: rtl/reachability_merge_cycle_check_core.sv
// Top level: config register, front end, command queue and back end.
`timescale 1ns / 1ps

// Reachability merge cycle check. Issue a command word with start while busy is low;
// busy rises only when the two-entry command queue is full. Clear and start-node
// words are handled in the idle state as they are popped, successor and member words
// read a row and then update, and a query walks every row of the matrix through the
// single read port of the row memory, with the answer held on o_creates_cycle and
// o_result_valid high for exactly one cycle as the answer is set. The receiver
// cannot stall; results must be taken as they appear. Rows are cleared by per-row
// valid bits, so reset and the clear command take effect at once with no sweep.
// Write op_count only while no command is pending.
module reachability_merge_cycle_check_core #(
    parameter int MAX_OPS = rmcc_pkg::MAX_OPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rmcc_pkg::OPC_W-1:0] i_opcode,
    input  logic [rmcc_pkg::IDX_W-1:0] i_op_index,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rmcc_pkg::CNT_W-1:0] i_cfg_data,
    output logic                      o_result_valid,
    output logic                      o_creates_cycle
);

    localparam logic [rmcc_pkg::CNT_W-1:0] MAX_N = rmcc_pkg::CNT_W'(MAX_OPS);

    logic [rmcc_pkg::CNT_W-1:0] r_op_count;
    logic [rmcc_pkg::CNT_W-1:0] live_n;

    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    rmcc_pkg::t_cmd front_cmd;
    rmcc_pkg::t_cmd back_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_count <= rmcc_pkg::OP_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_op_count <= i_cfg_data;
        end
    end

    // clamp the count to the matrix size
    assign live_n = (r_op_count > MAX_N) ? MAX_N : r_op_count;

    rmcc_front u_front (
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_op_index (i_op_index),
        .i_live_n   (live_n),
        .i_full     (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    rmcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rmcc_back #(
        .MAX_OPS (MAX_OPS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_live_n        (live_n),
        .i_empty         (q_empty),
        .i_cmd           (back_cmd),
        .o_pop           (pop),
        .o_result_valid  (o_result_valid),
        .o_creates_cycle (o_creates_cycle)
    );

endmodule
